// ===== rtl/ffsa_pkg.sv =====
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam int MEMORY_BYTES = 65536;
  localparam int MAX_SEGMENTS = 32;

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [15:0] MEM_LAST = 16'(MEMORY_BYTES - 1);
  localparam logic [CW-1:0] SEG_MAX = CW'(MAX_SEGMENTS);

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NOFIT = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_NOID  = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic [15:0] owner;
    logic        used;
    logic [15:0] last;
    logic [15:0] first;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  typedef struct packed {
    logic        req_type;
    logic [16:0] operand;
    logic [15:0] req_ref;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] block_start;
  } res_t;

endpackage

// ===== rtl/ffsa_ram.sv =====
`timescale 1ns / 1ps
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ffsa_ctrl.sv =====
`timescale 1ns / 1ps
module ffsa_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  ffsa_pkg::req_t              req,
  input  logic                        ack,
  output logic                        idle,
  output logic                        done,
  output ffsa_pkg::res_t              res,
  output logic                        mem_we,
  output logic [ffsa_pkg::IW-1:0]     mem_waddr,
  output ffsa_pkg::seg_t              mem_wdata,
  output logic [ffsa_pkg::IW-1:0]     mem_raddr,
  input  ffsa_pkg::seg_t              mem_rdata
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_FRD  = 4'd4;
  localparam logic [3:0] S_FMRG = 4'd5;
  localparam logic [3:0] S_CPRD = 4'd6;
  localparam logic [3:0] S_CPWR = 4'd7;
  localparam logic [3:0] S_AL1  = 4'd8;
  localparam logic [3:0] S_AL2  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  localparam int CW = ffsa_pkg::CW;
  localparam int IW = ffsa_pkg::IW;

  logic [3:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        src_r, src_nxt;
  logic [CW-1:0]        dst_r, dst_nxt;
  logic [1:0]           n_r, n_nxt;
  logic                 up_r, up_nxt;
  ffsa_pkg::seg_t       e_r, e_nxt;
  ffsa_pkg::seg_t       prev_r, prev_nxt;
  ffsa_pkg::req_t       req_r, req_nxt;
  ffsa_pkg::res_t       res_r, res_nxt;

  ffsa_pkg::seg_t       cur;
  logic [16:0]          hole;
  logic                 fit;
  logic                 match;
  logic                 has_next;
  logic                 mrg_prev;
  logic                 mrg_next;
  logic [CW-1:0]        wpos;
  ffsa_pkg::seg_t       merged;

  assign cur      = mem_rdata;
  assign hole     = {1'b0, cur.last} - {1'b0, cur.first} + 17'd1;
  assign fit      = !cur.used && (req_r.operand <= hole);
  assign match    = cur.used && ({1'b0, cur.owner} == req_r.operand);
  assign has_next = (idx_r + CW'(1)) < count_r;
  assign mrg_prev = (idx_r != '0) && !prev_r.used;
  assign mrg_next = has_next && !cur.used;
  assign wpos     = mrg_prev ? (idx_r - CW'(1)) : idx_r;

  // build the merged free segment around the released one
  always_comb begin
    merged       = e_r;
    merged.used  = 1'b0;
    merged.owner = 16'd0;
    if (mrg_prev) begin
      merged.first = prev_r.first;
    end
    if (mrg_next) begin
      merged.last = cur.last;
    end
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign res  = res_r;

  // sequencer: scan, shift and patch the segment table
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    n_nxt     = n_r;
    up_nxt    = up_r;
    e_nxt     = e_r;
    prev_nxt  = prev_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r[IW-1:0];
    mem_wdata = cur;
    mem_raddr = idx_r[IW-1:0];
    case (state_r)
      S_INIT: begin
        mem_we          = 1'b1;
        mem_waddr       = '0;
        mem_wdata.first = 16'd0;
        mem_wdata.last  = ffsa_pkg::MEM_LAST;
        mem_wdata.used  = 1'b0;
        mem_wdata.owner = 16'd0;
        state_nxt       = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          req_nxt = req;
          idx_nxt = '0;
          res_nxt = '0;
          if (req.req_type == ffsa_pkg::REQ_ALLOC && req.operand == 17'd0) begin
            res_nxt.status = ffsa_pkg::ST_ZERO;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (req_r.req_type == ffsa_pkg::REQ_ALLOC) begin
          if (fit) begin
            if (req_r.operand == hole) begin
              mem_we              = 1'b1;
              mem_wdata.used      = 1'b1;
              mem_wdata.owner     = req_r.req_ref;
              res_nxt.status      = ffsa_pkg::ST_OK;
              res_nxt.block_start = cur.first;
              state_nxt           = S_DONE;
            end else if (count_r >= ffsa_pkg::SEG_MAX) begin
              res_nxt.status = ffsa_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              // open a gap at this entry, copying from the top down
              e_nxt     = cur;
              up_nxt    = 1'b1;
              dst_nxt   = count_r;
              src_nxt   = count_r - CW'(1);
              state_nxt = S_CPRD;
            end
          end else if (has_next) begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_RD;
          end else begin
            res_nxt.status = ffsa_pkg::ST_NOFIT;
            state_nxt      = S_DONE;
          end
        end else begin
          if (match) begin
            e_nxt     = cur;
            state_nxt = S_FRD;
          end else if (has_next) begin
            prev_nxt  = cur;
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_RD;
          end else begin
            res_nxt.status = ffsa_pkg::ST_NOID;
            state_nxt      = S_DONE;
          end
        end
      end
      S_FRD: begin
        // fetch the right neighbor
        mem_raddr = IW'(idx_r + CW'(1));
        state_nxt = S_FMRG;
      end
      S_FMRG: begin
        mem_we         = 1'b1;
        mem_waddr      = wpos[IW-1:0];
        mem_wdata      = merged;
        res_nxt.status = ffsa_pkg::ST_OK;
        n_nxt          = {1'b0, mrg_prev} + {1'b0, mrg_next};
        up_nxt         = 1'b0;
        dst_nxt        = wpos + CW'(1);
        src_nxt        = wpos + CW'(1) + CW'({1'b0, mrg_prev} + {1'b0, mrg_next});
        if ((wpos + CW'(1) + CW'({1'b0, mrg_prev} + {1'b0, mrg_next})) < count_r) begin
          state_nxt = S_CPRD;
        end else begin
          count_nxt = count_r - CW'({1'b0, mrg_prev} + {1'b0, mrg_next});
          state_nxt = S_DONE;
        end
      end
      S_CPRD: begin
        mem_raddr = src_r[IW-1:0];
        state_nxt = S_CPWR;
      end
      S_CPWR: begin
        mem_we    = 1'b1;
        mem_waddr = dst_r[IW-1:0];
        mem_wdata = cur;
        if (up_r) begin
          if (dst_r == idx_r + CW'(1)) begin
            count_nxt = count_r + CW'(1);
            state_nxt = S_AL1;
          end else begin
            dst_nxt   = dst_r - CW'(1);
            src_nxt   = src_r - CW'(1);
            state_nxt = S_CPRD;
          end
        end else begin
          if ((src_r + CW'(1)) < count_r) begin
            dst_nxt   = dst_r + CW'(1);
            src_nxt   = src_r + CW'(1);
            state_nxt = S_CPRD;
          end else begin
            count_nxt = count_r - CW'(n_r);
            state_nxt = S_DONE;
          end
        end
      end
      S_AL1: begin
        // carve the block from the low end
        mem_we              = 1'b1;
        mem_waddr           = idx_r[IW-1:0];
        mem_wdata.first     = e_r.first;
        mem_wdata.last      = e_r.first + req_r.operand[15:0] - 16'd1;
        mem_wdata.used      = 1'b1;
        mem_wdata.owner     = req_r.req_ref;
        res_nxt.status      = ffsa_pkg::ST_OK;
        res_nxt.block_start = e_r.first;
        state_nxt           = S_AL2;
      end
      S_AL2: begin
        mem_we          = 1'b1;
        mem_waddr       = IW'(idx_r + CW'(1));
        mem_wdata.first = e_r.first + req_r.operand[15:0];
        mem_wdata.last  = e_r.last;
        mem_wdata.used  = 1'b0;
        mem_wdata.owner = e_r.owner;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      count_r <= CW'(1);
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
    n_r    <= n_nxt;
    up_r   <= up_nxt;
    e_r    <= e_nxt;
    prev_r <= prev_nxt;
    req_r  <= req_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ===== rtl/first_fit_segment_allocator_unit.sv =====
`timescale 1ns / 1ps
// First-fit segment allocator. Each input word is one request (tuser = 0
// allocate, 1 free by owner id) and yields exactly one output word with a
// status and, for a successful allocate, the block start. The segment table
// lives in a single-port-read, single-port-write RAM; a request scans it
// entry by entry, and a split or merge shifts the table one moved entry at
// a time, reading and then writing it, so a new word is taken only once the
// controller is idle again. After reset the controller writes the initial
// free segment before the first word is taken. A result sits in an output
// register, so the next request starts while it waits.
module first_fit_segment_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [16:0] operand, [32:17] req_ref, rest zero
  input  logic [0:0]  in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] status, [18:3] block_start, rest zero
);

  logic                        ctrl_idle;
  logic                        ctrl_done;
  logic                        ack;
  ffsa_pkg::req_t              req;
  ffsa_pkg::res_t              res;
  logic                        mem_we;
  logic [ffsa_pkg::IW-1:0]     mem_waddr;
  ffsa_pkg::seg_t              mem_wdata;
  logic [ffsa_pkg::IW-1:0]     mem_raddr;
  ffsa_pkg::seg_t              mem_rdata;
  logic                        out_valid_r, out_valid_nxt;
  ffsa_pkg::res_t              out_res_r;

  // unpack the request word
  assign req       = {in_tuser[0], in_tdata[16:0], in_tdata[32:17]};
  assign in_tready = ctrl_idle;

  // hand a finished result to the output register when it is free
  assign ack           = ctrl_done && (!out_valid_r || out_tready);
  assign out_valid_nxt = ack || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.block_start, out_res_r.status};

  ffsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && ctrl_idle),
    .req       (req),
    .ack       (ack),
    .idle      (ctrl_idle),
    .done      (ctrl_done),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ffsa_ram #(
    .WIDTH (ffsa_pkg::SEG_W),
    .DEPTH (ffsa_pkg::MAX_SEGMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== bench/ffsa_checker.sv =====
`timescale 1ns / 1ps
module ffsa_checker
  import ffsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  output int          fail_count,
  output int          pending
);

  logic [15:0] tbl_first [MAX_SEGMENTS];
  logic [15:0] tbl_last  [MAX_SEGMENTS];
  logic        tbl_used  [MAX_SEGMENTS];
  logic [15:0] tbl_owner [MAX_SEGMENTS];
  int          tbl_count;
  res_t        exp_buf [16];
  int          exp_wr;
  int          exp_rd;

  assign pending = exp_wr - exp_rd;

  // Shift entries down from idx, dropping entry idx
  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < tbl_count; k++) begin
      tbl_first[k] = tbl_first[k+1];
      tbl_last[k]  = tbl_last[k+1];
      tbl_used[k]  = tbl_used[k+1];
      tbl_owner[k] = tbl_owner[k+1];
    end
    tbl_count--;
  endfunction

  function automatic res_t allocate_block(logic [16:0] size, logic [15:0] owner);
    res_t r;
    int hole;
    r = '{status: ST_NOFIT, block_start: 16'd0};
    if (size == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    for (int i = 0; i < tbl_count; i++) begin
      hole = int'(tbl_last[i]) - int'(tbl_first[i]) + 1;
      if (tbl_used[i] || int'(size) > hole) continue;
      if (int'(size) == hole) begin
        tbl_used[i] = 1'b1;
        tbl_owner[i] = owner;
        r = '{status: ST_OK, block_start: tbl_first[i]};
        return r;
      end
      if (tbl_count >= MAX_SEGMENTS) begin
        r.status = ST_FULL;
        return r;
      end
      // Open a slot at i; the remaining free part moves to i+1
      for (int k = tbl_count; k > i; k--) begin
        tbl_first[k] = tbl_first[k-1];
        tbl_last[k]  = tbl_last[k-1];
        tbl_used[k]  = tbl_used[k-1];
        tbl_owner[k] = tbl_owner[k-1];
      end
      tbl_count++;
      tbl_last[i] = tbl_first[i] + 16'(size - 1);
      tbl_used[i] = 1'b1;
      tbl_owner[i] = owner;
      tbl_first[i+1] = tbl_last[i] + 16'd1;
      r = '{status: ST_OK, block_start: tbl_first[i]};
      return r;
    end
    return r;
  endfunction

  function automatic res_t release_block(logic [16:0] id);
    res_t r;
    int j;
    r = '{status: ST_NOID, block_start: 16'd0};
    for (int i = 0; i < tbl_count; i++) begin
      if (!tbl_used[i] || {1'b0, tbl_owner[i]} != id) continue;
      j = i;
      tbl_used[j] = 1'b0;
      tbl_owner[j] = '0;
      // Merge with free neighbors on both sides
      if (j > 0 && !tbl_used[j-1]) begin
        tbl_last[j-1] = tbl_last[j];
        drop_entry(j);
        j--;
      end
      if (j + 1 < tbl_count && !tbl_used[j+1]) begin
        tbl_last[j] = tbl_last[j+1];
        drop_entry(j + 1);
      end
      r.status = ST_OK;
      return r;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        tbl_first[k] = '0;
        tbl_last[k]  = '0;
        tbl_used[k]  = 1'b0;
        tbl_owner[k] = '0;
      end
      tbl_last[0] = MEM_LAST;
      tbl_count = 1;
      fail_count = 0;
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      // Predict each accepted request word
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == REQ_ALLOC)
          exp_buf[exp_wr & 15] = allocate_block(in_tdata[16:0], in_tdata[32:17]);
        else
          exp_buf[exp_wr & 15] = release_block(in_tdata[16:0]);
        exp_wr++;
      end
      // Compare each accepted result word
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[2:0];
        got.block_start = out_tdata[18:3];
        if (exp_wr == exp_rd) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word: %p", got);
        end else begin
          want = exp_buf[exp_rd & 15];
          exp_rd++;
          if (got.status !== want.status || got.block_start !== want.block_start
              || out_tdata[23:19] !== 5'd0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected status %0d start %0d, got status %0d start %0d",
                       want.status, want.block_start, got.status, got.block_start);
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_first_fit_segment_allocator_unit.sv =====
`timescale 1ns / 1ps
module tb_first_fit_segment_allocator_unit;
  import ffsa_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [15:0] live_ids [4096];
  int          live_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_fit_segment_allocator_unit dut (.*);

  ffsa_checker u_checker (.*);

  // Stall the result side at random
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Send one request word, idling at random before it
  task automatic send_req(logic kind, logic [16:0] opnd, logic [15:0] owner);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, owner, opnd};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic alloc_req(logic [16:0] size);
    logic [15:0] owner;
    owner = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    if (live_cnt < 4096) begin
      live_ids[live_cnt] = owner;
      live_cnt++;
    end
    send_req(REQ_ALLOC, size, owner);
  endtask

  task automatic free_req();
    logic [16:0] id;
    int k;
    if (live_cnt > 0 && $urandom_range(9) != 0) begin
      k = $urandom_range(live_cnt - 1);
      id = {1'b0, live_ids[k]};
      live_ids[k] = live_ids[live_cnt - 1];
      live_cnt--;
    end else begin
      id = 17'($urandom);
    end
    send_req(REQ_FREE, id, 16'($urandom));
  endtask

  task automatic run_phase(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        // Mostly small blocks so the table fills and splits
        if ($urandom_range(19) == 0) alloc_req(17'($urandom_range(65536)));
        else alloc_req(17'($urandom_range(1, 3000)));
      end else begin
        free_req();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, exact fits, zero size, unknown ids, duplicates
    send_req(REQ_ALLOC, 17'd0, 16'hFFFF);
    send_req(REQ_ALLOC, 17'd65537, 16'd1);
    send_req(REQ_ALLOC, 17'd65536, 16'hFFFF);
    send_req(REQ_FREE, 17'h1FFFF, 16'd0);
    send_req(REQ_FREE, 17'h0FFFF, 16'hFFFF);
    send_req(REQ_ALLOC, 17'd100, 16'd0);
    send_req(REQ_ALLOC, 17'd200, 16'd7);
    send_req(REQ_ALLOC, 17'd300, 16'd7);
    send_req(REQ_FREE, 17'd7, 16'd0);
    send_req(REQ_ALLOC, 17'd200, 16'd9);
    send_req(REQ_FREE, 17'd0, 16'd0);
    send_req(REQ_FREE, 17'd7, 16'd0);
    send_req(REQ_FREE, 17'd9, 16'd0);
    send_req(REQ_FREE, 17'd9, 16'd0);
    // Fill the table to force the full case
    for (int i = 0; i < 33; i++) send_req(REQ_ALLOC, 17'd1, 16'(i + 100));
    send_req(REQ_ALLOC, 17'd70000, 16'd1);
    for (int i = 0; i < 33; i++) send_req(REQ_FREE, 17'(i + 100), 16'd0);

    // Random phases with different idle and stall mixes
    send_idle_pct = 0;  recv_stall_pct = 0;  run_phase(400);
    send_idle_pct = 80; recv_stall_pct = 0;  run_phase(350);
    send_idle_pct = 0;  recv_stall_pct = 80; run_phase(350);
    send_idle_pct = 32; recv_stall_pct = 32; run_phase(400);
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
